FILE: rtl/core/tkst_pkg.sv
// Package for the time-keyed sorted table: sizes, codes and word types.
`timescale 1ns / 1ps

package tkst_pkg;

  localparam int CAPACITY = 64;
  localparam int ID_BITS  = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_CANCEL = 2'd1;
  localparam logic [1:0] CMD_STATUS = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_BAD_TIME  = 2'd3;

  localparam logic [4:0] MAX_HOUR = 5'd23;
  localparam logic [5:0] MAX_MS   = 6'd59;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } fsm_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] flight_id;
    logic [4:0]  eta_hour;
    logic [5:0]  eta_min;
    logic [5:0]  eta_sec;
  } in_word_t;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] found_hour;
    logic [5:0] found_min;
    logic [5:0] found_sec;
    logic [6:0] held_count;
  } out_word_t;

  typedef struct packed {
    logic [ID_BITS-1:0] id;
    logic [4:0]         hour;
    logic [5:0]         min;
    logic [5:0]         sec;
  } entry_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic   insert;
    logic   remove;
    entry_t key;
  } cell_ctrl_t;

endpackage

FILE: rtl/core/tkst_cell.sv
// One slot of the sorted chain: compare against the broadcast key and shift.
`timescale 1ns / 1ps

module tkst_cell (
  input  logic                clk,
  input  logic                occupied,
  input  tkst_pkg::cell_ctrl_t ctrl,
  input  tkst_pkg::entry_t    left_ent,
  input  logic                left_gt,
  input  logic                left_seen,
  input  tkst_pkg::entry_t    left_found,
  input  tkst_pkg::entry_t    right_ent,
  output tkst_pkg::entry_t    ent,
  output logic                gt,
  output logic                seen,
  output tkst_pkg::entry_t    found
);
  import tkst_pkg::*;

  entry_t ent_r;
  entry_t ent_nxt;
  logic   match;

  assign ent = ent_r;

  // Empty slots sort after everything, so the insert point is the first gt.
  assign gt = !occupied ||
              ({ent_r.hour, ent_r.min, ent_r.sec} >
               {ctrl.key.hour, ctrl.key.min, ctrl.key.sec});

  assign match = occupied && (ent_r.id == ctrl.key.id);
  assign seen  = left_seen || match;

  // Carry the first matching entry down the chain.
  assign found = left_seen ? left_found : (match ? ent_r : '0);

  always_comb begin
    ent_nxt = ent_r;
    if (ctrl.insert && gt) begin
      ent_nxt = left_gt ? left_ent : ctrl.key;
    end else if (ctrl.remove && seen) begin
      ent_nxt = right_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

FILE: rtl/core/time_keyed_sorted_table.sv
// Top level of the time-keyed sorted table: controller and chain of cells.
`timescale 1ns / 1ps

// Channel   Ports                    Direction  Handshake
// command   start, busy, in_word     in         taken when start && !busy
// result    out_valid, out_word      out        one-cycle strobe, always taken
//
// A command is taken while idle and executed in the next cycle: every cell
// compares in parallel and the match and shift ripple through the chain.
// The result word appears in the cycle after execution, together with busy
// low, so the next command may be taken in the cycle its result appears.
// Synchronous active-low reset empties the table; slot contents are not cleared.
// The receiver cannot stall; no result is held back.

module time_keyed_sorted_table (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  tkst_pkg::in_word_t  in_word,
  output logic                out_valid,
  output tkst_pkg::out_word_t out_word
);
  import tkst_pkg::*;

  fsm_t       state_r, state_nxt;
  in_word_t   cmd_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_word_t  out_word_r, out_word_nxt;

  cell_ctrl_t ctrl;
  entry_t     ents   [CAPACITY];
  entry_t     founds [CAPACITY];
  logic [CAPACITY-1:0] gts, seens, occ;

  logic bad_time, full, hit, exec;

  assign busy      = (state_r == S_EXEC);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  assign exec     = (state_r == S_EXEC);
  assign bad_time = (cmd_r.eta_hour > MAX_HOUR) || (cmd_r.eta_min > MAX_MS) ||
                    (cmd_r.eta_sec > MAX_MS);
  assign full     = (count_r >= CNT_W'(CAPACITY));
  assign hit      = seens[CAPACITY-1];

  assign ctrl.key.id   = ID_BITS'(cmd_r.flight_id);
  assign ctrl.key.hour = cmd_r.eta_hour;
  assign ctrl.key.min  = cmd_r.eta_min;
  assign ctrl.key.sec  = cmd_r.eta_sec;
  assign ctrl.insert   = exec && (cmd_r.cmd == CMD_INSERT) && !bad_time && !full;
  assign ctrl.remove   = exec && (cmd_r.cmd == CMD_CANCEL) && hit;

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      assign occ[i] = (CNT_W'(i) < count_r);
      if (i == 0) begin : g_head
        tkst_cell u_cell (
          .clk        (clk),
          .occupied   (occ[i]),
          .ctrl       (ctrl),
          .left_ent   ('0),
          .left_gt    (1'b0),
          .left_seen  (1'b0),
          .left_found ('0),
          .right_ent  (ents[i+1]),
          .ent        (ents[i]),
          .gt         (gts[i]),
          .seen       (seens[i]),
          .found      (founds[i])
        );
      end else if (i == CAPACITY - 1) begin : g_tail
        tkst_cell u_cell (
          .clk        (clk),
          .occupied   (occ[i]),
          .ctrl       (ctrl),
          .left_ent   (ents[i-1]),
          .left_gt    (gts[i-1]),
          .left_seen  (seens[i-1]),
          .left_found (founds[i-1]),
          .right_ent  ('0),
          .ent        (ents[i]),
          .gt         (gts[i]),
          .seen       (seens[i]),
          .found      (founds[i])
        );
      end else begin : g_mid
        tkst_cell u_cell (
          .clk        (clk),
          .occupied   (occ[i]),
          .ctrl       (ctrl),
          .left_ent   (ents[i-1]),
          .left_gt    (gts[i-1]),
          .left_seen  (seens[i-1]),
          .left_found (founds[i-1]),
          .right_ent  (ents[i+1]),
          .ent        (ents[i]),
          .gt         (gts[i]),
          .seen       (seens[i]),
          .found      (founds[i])
        );
      end
    end
  endgenerate

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt               = S_IDLE;
        out_valid_nxt           = 1'b1;
        out_word_nxt            = '0;
        out_word_nxt.status     = ST_OK;
        case (cmd_r.cmd)
          CMD_INSERT: begin
            if (bad_time) begin
              out_word_nxt.status = ST_BAD_TIME;
            end else if (full) begin
              out_word_nxt.status = ST_FULL;
            end else begin
              out_word_nxt.found_hour = cmd_r.eta_hour;
              out_word_nxt.found_min  = cmd_r.eta_min;
              out_word_nxt.found_sec  = cmd_r.eta_sec;
              count_nxt               = count_r + 1'b1;
            end
          end
          CMD_CANCEL, CMD_STATUS: begin
            if (!hit) begin
              out_word_nxt.status = ST_NOT_FOUND;
            end else begin
              out_word_nxt.found_hour = founds[CAPACITY-1].hour;
              out_word_nxt.found_min  = founds[CAPACITY-1].min;
              out_word_nxt.found_sec  = founds[CAPACITY-1].sec;
              if (cmd_r.cmd == CMD_CANCEL) begin
                count_nxt = count_r - 1'b1;
              end
            end
          end
          default: begin
            // unused command: report ok, change nothing
          end
        endcase
        out_word_nxt.held_count = 7'(count_nxt);
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
    if (start && !busy) begin
      cmd_r <= in_word;
    end
  end

  a_result_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == S_EXEC))
    else $error("result strobe without an executed command");

  a_busy_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy)
    else $error("busy held past one execute cycle");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("held count above capacity");

  a_fail_zero_time: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_word_r.status != ST_OK)) |->
      (out_word_r.found_hour == '0 && out_word_r.found_min == '0 &&
       out_word_r.found_sec == '0))
    else $error("failed command reports a time");

endmodule

FILE: bench/time_keyed_sorted_table_tb.sv
// Self-checking testbench for the time-keyed sorted table.
`timescale 1ns / 1ps

module time_keyed_sorted_table_tb;
  import tkst_pkg::*;

  localparam logic [1:0] CMD_NOP = 2'd3;
  localparam int STALL_LIMIT = 2000;
  localparam int MAX_GAP = 20;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_word_t  in_word;
  logic      out_valid;
  out_word_t out_word;

  // Shadow copy of the table, updated as each command word is taken.
  entry_t shadow[CAPACITY];
  int     shadow_count;

  out_word_t pending_replies[$];
  int        sender_idle_pct;
  int        n_sent;
  int        n_checked = 0;
  int        n_fail = 0;
  int        stall_cycles = 0;

  time_keyed_sorted_table dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_word (out_word)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Apply one command to the shadow table and return the reply it should produce.
  function automatic out_word_t shadow_apply(input in_word_t w);
    out_word_t r;
    entry_t    e;
    int        i;
    int        pos;
    int        hit;
    r = '0;
    e.id   = w.flight_id[ID_BITS-1:0];
    e.hour = w.eta_hour;
    e.min  = w.eta_min;
    e.sec  = w.eta_sec;
    case (w.cmd)
      CMD_INSERT: begin
        if (w.eta_hour > MAX_HOUR || w.eta_min > MAX_MS || w.eta_sec > MAX_MS) begin
          r.status = ST_BAD_TIME;
        end else if (shadow_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          // equal times go after the ones already held
          pos = shadow_count;
          for (i = 0; i < shadow_count; i++) begin
            if (pos == shadow_count &&
                {shadow[i].hour, shadow[i].min, shadow[i].sec} > {e.hour, e.min, e.sec})
              pos = i;
          end
          for (i = shadow_count; i > pos; i--) shadow[i] = shadow[i-1];
          shadow[pos] = e;
          shadow_count++;
          r.status     = ST_OK;
          r.found_hour = e.hour;
          r.found_min  = e.min;
          r.found_sec  = e.sec;
        end
      end
      CMD_CANCEL, CMD_STATUS: begin
        hit = -1;
        for (i = 0; i < shadow_count; i++) begin
          if (hit < 0 && shadow[i].id == e.id) hit = i;
        end
        if (hit < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          r.status     = ST_OK;
          r.found_hour = shadow[hit].hour;
          r.found_min  = shadow[hit].min;
          r.found_sec  = shadow[hit].sec;
          if (w.cmd == CMD_CANCEL) begin
            for (i = hit; i + 1 < shadow_count; i++) shadow[i] = shadow[i+1];
            shadow_count--;
          end
        end
      end
      default: r.status = ST_OK;
    endcase
    r.held_count = 7'(shadow_count);
    return r;
  endfunction

  function automatic in_word_t make_word(input logic [1:0] cmd, input logic [15:0] id,
                                         input logic [4:0] h, input logic [5:0] m,
                                         input logic [5:0] s);
    in_word_t w;
    w.cmd       = cmd;
    w.flight_id = id;
    w.eta_hour  = h;
    w.eta_min   = m;
    w.eta_sec   = s;
    return w;
  endfunction

  // Random command; cancel and status mostly target an id that is held.
  function automatic in_word_t random_word(input int insert_pct, input int cancel_pct);
    in_word_t w;
    int       pick;
    int       shape;
    pick  = $urandom_range(99);
    shape = $urandom_range(99);
    if (pick < insert_pct) w.cmd = CMD_INSERT;
    else if (pick < insert_pct + cancel_pct) w.cmd = CMD_CANCEL;
    else if (pick >= 97) w.cmd = CMD_NOP;
    else w.cmd = CMD_STATUS;
    if (shape < 12) begin
      w.eta_hour = 5'($urandom_range(31));
      w.eta_min  = 6'($urandom_range(63));
      w.eta_sec  = 6'($urandom_range(63));
    end else if (shape < 40) begin
      // crowd a few times together to get ties
      w.eta_hour = 5'($urandom_range(1));
      w.eta_min  = 6'($urandom_range(1));
      w.eta_sec  = 6'($urandom_range(2));
    end else begin
      w.eta_hour = 5'($urandom_range(23));
      w.eta_min  = 6'($urandom_range(59));
      w.eta_sec  = 6'($urandom_range(59));
    end
    if (w.cmd != CMD_INSERT && shadow_count > 0 && $urandom_range(99) < 75)
      w.flight_id = 16'(shadow[$urandom_range(shadow_count - 1)].id);
    else if ($urandom_range(99) < 40)
      w.flight_id = 16'($urandom_range(7));
    else
      w.flight_id = 16'($urandom);
    return w;
  endfunction

  task automatic send_word(input in_word_t w);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start   = 1'b1;
    in_word = w;
    do @(posedge clk); while (busy);
    pending_replies.push_back(shadow_apply(w));
    n_sent++;
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    start = 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [6:0] want,
                             input logic [6:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_fail++;
    end
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid) begin
      if (pending_replies.size() == 0) begin
        $error("reply word with nothing outstanding: %h", out_word);
        n_fail++;
      end else begin
        want = pending_replies.pop_front();
        check_field("status", 7'(want.status), 7'(out_word.status));
        check_field("found_hour", 7'(want.found_hour), 7'(out_word.found_hour));
        check_field("found_min", 7'(want.found_min), 7'(out_word.found_min));
        check_field("found_sec", 7'(want.found_sec), 7'(out_word.found_sec));
        check_field("held_count", want.held_count, out_word.held_count);
        n_checked++;
      end
    end
  end

  // Abort if neither a command nor a reply moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles + 1 >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic test_directed();
    send_word(make_word(CMD_STATUS, 16'h1234, 5'd0, 6'd0, 6'd0));
    send_word(make_word(CMD_CANCEL, 16'hFFFF, 5'd31, 6'd63, 6'd63));
    send_word(make_word(CMD_NOP, 16'hFFFF, 5'd31, 6'd63, 6'd63));
    send_word(make_word(CMD_INSERT, 16'hFFFF, 5'd23, 6'd59, 6'd59));
    send_word(make_word(CMD_INSERT, 16'h0000, 5'd0, 6'd0, 6'd0));
    send_word(make_word(CMD_INSERT, 16'hABCD, 5'd12, 6'd30, 6'd30));
    // same id and same time: the second lands behind the first
    send_word(make_word(CMD_INSERT, 16'hABCD, 5'd12, 6'd30, 6'd30));
    send_word(make_word(CMD_INSERT, 16'h5555, 5'd12, 6'd30, 6'd30));
    send_word(make_word(CMD_INSERT, 16'hABCD, 5'd6, 6'd15, 6'd45));
    send_word(make_word(CMD_INSERT, 16'h1111, 5'd24, 6'd0, 6'd0));
    send_word(make_word(CMD_INSERT, 16'h1111, 5'd31, 6'd63, 6'd63));
    send_word(make_word(CMD_INSERT, 16'h1111, 5'd0, 6'd60, 6'd0));
    send_word(make_word(CMD_INSERT, 16'h1111, 5'd0, 6'd0, 6'd60));
    send_word(make_word(CMD_STATUS, 16'hABCD, 5'd31, 6'd63, 6'd63));
    send_word(make_word(CMD_CANCEL, 16'hABCD, 5'd31, 6'd63, 6'd63));
    send_word(make_word(CMD_STATUS, 16'hABCD, 5'd0, 6'd0, 6'd0));
    send_word(make_word(CMD_CANCEL, 16'hABCD, 5'd0, 6'd0, 6'd0));
    send_word(make_word(CMD_CANCEL, 16'hABCD, 5'd0, 6'd0, 6'd0));
    send_word(make_word(CMD_STATUS, 16'hABCD, 5'd0, 6'd0, 6'd0));
    send_word(make_word(CMD_STATUS, 16'h0000, 5'd0, 6'd0, 6'd0));
    send_word(make_word(CMD_CANCEL, 16'h0000, 5'd0, 6'd0, 6'd0));
    send_word(make_word(CMD_CANCEL, 16'hFFFF, 5'd0, 6'd0, 6'd0));
    send_word(make_word(CMD_CANCEL, 16'h5555, 5'd0, 6'd0, 6'd0));
    send_word(make_word(CMD_NOP, 16'h0000, 5'd0, 6'd0, 6'd0));
    hold_until_drained();
  endtask

  task automatic test_fill_and_drain();
    int guard;
    guard = 0;
    while (shadow_count < CAPACITY && guard < 400) begin
      send_word(random_word(92, 4));
      guard++;
    end
    // hammer the full table, bad times included
    repeat (12) send_word(random_word(92, 4));
    hold_until_drained();
    guard = 0;
    while (shadow_count > 0 && guard < 600) begin
      send_word(random_word(3, 80));
      guard++;
    end
    hold_until_drained();
  endtask

  task automatic test_random_mix(input int n_words);
    repeat (n_words) begin
      send_word(random_word(35, 35));
      if ($urandom_range(59) == 0) hold_until_drained();
    end
    hold_until_drained();
  endtask

  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    in_word      = '0;
    shadow_count = 0;
    n_sent       = 0;
    sender_idle_pct = 37;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_fill_and_drain();
    test_random_mix(275);
    sender_idle_pct = 67;
    test_random_mix(275);
    sender_idle_pct = 0;
    test_random_mix(275);

    repeat (8) @(posedge clk);
    if (pending_replies.size() != 0) begin
      $error("%0d expected replies never arrived", pending_replies.size());
    end
    $display("Sent %0d commands and checked %0d replies: edge and bad times, ties,",
             n_sent, n_checked);
    $display("duplicate ids, a full table and drain, random mixes at 37, 67, 0 pct gaps.");
    if (n_fail == 0 && pending_replies.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
